// ----- hw/rtl/pkbc_pkg.sv -----
// ----------------------------------------------------------------------------
// pkbc_pkg - shared types and constants of the per-key packet byte counter
// Command format between front and back, result format, status codes.
// ----------------------------------------------------------------------------
package pkbc_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 128;

    localparam logic [15:0] IPV4_ETHERTYPE   = 16'h0800;
    localparam logic [15:0] ETH_HDR_BYTES    = 16'd14;
    localparam logic [15:0] ETH_IP_HDR_BYTES = 16'd34;

    // command queue between classifier and table engine
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_FIFO_AW    = 2;

    typedef enum logic [1:0] {
        CMD_COUNT  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_IGNORE = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] key;
        logic [15:0] length;
        logic [6:0]  slot;
    } cmd_t;

    typedef enum logic [2:0] {
        STATUS_HIT      = 3'd0,
        STATUS_INSERTED = 3'd1,
        STATUS_IGNORED  = 3'd2,
        STATUS_FULL     = 3'd3,
        STATUS_READ     = 3'd4
    } status_t;

    typedef struct packed {
        logic [63:0] bytes;
        logic [63:0] packets;
    } counts_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] byte_count;
        logic [63:0] packet_count;
        logic [31:0] entry_key;
        logic        entry_valid;
        logic [6:0]  slot;
    } result_t;

endpackage

// ----- hw/rtl/pkbc_front.sv -----
// ----------------------------------------------------------------------------
// pkbc_front - descriptor classifier
// Holds the key mode register, filters frames and builds table commands.
// ----------------------------------------------------------------------------
module pkbc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [103:0]   s_axis_tdata,
    input  logic           s_axis_tuser,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output pkbc_pkg::cmd_t cmd
);

    logic        key_mode_reg;
    logic        key_mode_next;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [31:0] source_ip;
    logic [31:0] ingress_index;
    logic [6:0]  slot_index;
    logic        malformed;

    assign cfg_ready = 1'b1;

    assign key_mode_next = (cfg_valid && cfg_ready) ? cfg_data : key_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_mode_reg <= 1'b0;
        end else begin
            key_mode_reg <= key_mode_next;
        end
    end

    assign frame_length  = s_axis_tdata[15:0];
    assign ether_type    = s_axis_tdata[31:16];
    assign source_ip     = s_axis_tdata[63:32];
    assign ingress_index = s_axis_tdata[95:64];
    assign slot_index    = s_axis_tdata[102:96];

    assign malformed = (frame_length < pkbc_pkg::ETH_HDR_BYTES) ||
                       (ether_type != pkbc_pkg::IPV4_ETHERTYPE) ||
                       (frame_length < pkbc_pkg::ETH_IP_HDR_BYTES);

    always_comb begin
        cmd.length = frame_length;
        cmd.slot   = slot_index;
        cmd.key    = key_mode_reg ? ingress_index : source_ip;
        if (s_axis_tuser) begin
            cmd.op = pkbc_pkg::CMD_READ;
        end else if (!key_mode_reg && malformed) begin
            cmd.op = pkbc_pkg::CMD_IGNORE;
        end else begin
            cmd.op = pkbc_pkg::CMD_COUNT;
        end
    end

    assign cmd_valid     = s_axis_tvalid;
    assign s_axis_tready = cmd_ready;

endmodule

// ----- hw/rtl/pkbc_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// pkbc_cmd_fifo - command queue
// Small first-in first-out buffer that decouples classifier and table engine.
// ----------------------------------------------------------------------------
module pkbc_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  pkbc_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_en,
    output pkbc_pkg::cmd_t rd_data
);

    localparam int AW = pkbc_pkg::CMD_FIFO_AW;
    localparam int CW = AW + 1;

    pkbc_pkg::cmd_t mem_reg [pkbc_pkg::CMD_FIFO_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push;
    logic           pop;

    assign wr_ready = (count_reg != CW'(pkbc_pkg::CMD_FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    assign push = wr_valid && wr_ready;
    assign pop  = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/pkbc_back.sv -----
// ----------------------------------------------------------------------------
// pkbc_back - table engine
// Key and count memories, sequential key search, counter update, result reg.
// ----------------------------------------------------------------------------
module pkbc_back #(
    parameter int TABLE_ENTRIES = pkbc_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  pkbc_pkg::cmd_t    cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output pkbc_pkg::result_t res
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = (CW > 7) ? CW : 7;

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_SCAN      = 4'b0010,
        S_HIT       = 4'b0100,
        S_READ_WAIT = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    pkbc_pkg::cmd_t       cmd_reg, cmd_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic                 out_valid_reg, out_valid_next;
    pkbc_pkg::result_t    out_reg, out_next;

    // entries are filled from slot 0 upward and never freed, so the live
    // slots are exactly those below the fill count
    logic [31:0]          key_mem [TABLE_ENTRIES];
    pkbc_pkg::counts_t    cnt_mem [TABLE_ENTRIES];
    logic [31:0]          key_q;
    pkbc_pkg::counts_t    cnt_q;
    logic [AW-1:0]        key_raddr;
    logic [AW-1:0]        cnt_raddr;
    logic                 key_we;
    logic                 cnt_we;
    logic [AW-1:0]        waddr;
    logic [31:0]          key_wdata;
    pkbc_pkg::counts_t    cnt_wdata;

    logic                 out_free;
    logic                 ins;
    pkbc_pkg::cmd_t       ins_cmd;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        key_raddr      = '0;
        cnt_raddr      = '0;
        key_we         = 1'b0;
        cnt_we         = 1'b0;
        waddr          = '0;
        key_wdata      = '0;
        cnt_wdata      = '0;
        ins            = 1'b0;
        ins_cmd        = cmd_reg;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    case (cmd.op)
                        pkbc_pkg::CMD_READ: begin
                            if (SW'(cmd.slot) < SW'(fill_reg)) begin
                                key_raddr  = AW'(cmd.slot);
                                cnt_raddr  = AW'(cmd.slot);
                                state_next = S_READ_WAIT;
                            end else begin
                                out_valid_next = 1'b1;
                                out_next       = '0;
                                out_next.status = pkbc_pkg::STATUS_READ;
                                out_next.slot   = cmd.slot;
                            end
                        end
                        pkbc_pkg::CMD_COUNT: begin
                            if (fill_reg == '0) begin
                                ins     = 1'b1;
                                ins_cmd = cmd;
                            end else begin
                                key_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            out_valid_next  = 1'b1;
                            out_next        = '0;
                            out_next.status = pkbc_pkg::STATUS_IGNORED;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (key_q == cmd_reg.key) begin
                    cnt_raddr  = idx_reg;
                    state_next = S_HIT;
                end else if (CW'(idx_reg) + CW'(1) == fill_reg) begin
                    ins        = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    key_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end
            S_HIT: begin
                cnt_we            = 1'b1;
                waddr             = idx_reg;
                cnt_wdata.packets = cnt_q.packets + 64'd1;
                cnt_wdata.bytes   = cnt_q.bytes + 64'(cmd_reg.length);
                out_valid_next        = 1'b1;
                out_next.status       = pkbc_pkg::STATUS_HIT;
                out_next.slot         = 7'(idx_reg);
                out_next.entry_valid  = 1'b1;
                out_next.entry_key    = cmd_reg.key;
                out_next.packet_count = cnt_wdata.packets;
                out_next.byte_count   = cnt_wdata.bytes;
                state_next            = S_IDLE;
            end
            S_READ_WAIT: begin
                out_valid_next        = 1'b1;
                out_next.status       = pkbc_pkg::STATUS_READ;
                out_next.slot         = cmd_reg.slot;
                out_next.entry_valid  = 1'b1;
                out_next.entry_key    = key_q;
                out_next.packet_count = cnt_q.packets;
                out_next.byte_count   = cnt_q.bytes;
                state_next            = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // miss: take the next free slot, or report the table full
        if (ins) begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (fill_reg < CW'(TABLE_ENTRIES)) begin
                key_we            = 1'b1;
                cnt_we            = 1'b1;
                waddr             = AW'(fill_reg);
                key_wdata         = ins_cmd.key;
                cnt_wdata.packets = 64'd1;
                cnt_wdata.bytes   = 64'(ins_cmd.length);
                fill_next         = fill_reg + CW'(1);
                out_next.status       = pkbc_pkg::STATUS_INSERTED;
                out_next.slot         = 7'(fill_reg);
                out_next.entry_valid  = 1'b1;
                out_next.entry_key    = ins_cmd.key;
                out_next.packet_count = 64'd1;
                out_next.byte_count   = 64'(ins_cmd.length);
            end else begin
                out_next.status    = pkbc_pkg::STATUS_FULL;
                out_next.entry_key = ins_cmd.key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[waddr] <= key_wdata;
        end
        key_q <= key_mem[key_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[cnt_raddr];
    end

endmodule

// ----- hw/rtl/per_key_packet_byte_counter_unit.sv -----
// ----------------------------------------------------------------------------
// per_key_packet_byte_counter_unit - per-key packet and byte counter
// Counts packets and bytes per IPv4 source address or per ingress port.
// ----------------------------------------------------------------------------
// s_axis carries one descriptor per transfer (tuser 0) or a slot read
// request (tuser 1); m_axis returns exactly one result per input transfer,
// in order. cfg writes the key mode (0 source address, 1 ingress port) and
// is always ready; change it only while the block is idle.
// A classifier filters frames and forms commands into a four-entry queue;
// the table engine works through them one at a time against a key memory
// and a count memory, each with one registered read port.
// After a command leaves the queue, an ignored frame, a read of a free slot and
// a counted frame on an empty table take their result from the idle state; a
// read of a live slot waits in S_READ_WAIT for both memories; other counted
// frames search the live entries in S_SCAN, stepping through the key memory one
// entry per cycle, and a hit updates its counts in S_HIT. Entries fill from slot 0.
// Reset empties the table at once (the fill count clears), sets the key
// mode to source address and drops queued commands and results.
// When m_axis stalls, the finished result waits in the output register
// while the queue keeps accepting descriptors until it is full.
// ----------------------------------------------------------------------------
module per_key_packet_byte_counter_unit #(
    parameter int TABLE_ENTRIES = pkbc_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,        // key_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // frame_length, ether_type, source_ip, ingress_index, slot_index, pad
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tuser,    // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot, entry_valid, entry_key, packet_count, byte_count
    output logic [167:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser     // status
);

    pkbc_pkg::cmd_t    front_cmd;
    logic              front_valid;
    logic              front_ready;
    pkbc_pkg::cmd_t    queue_cmd;
    logic              queue_valid;
    logic              queue_pop;
    pkbc_pkg::result_t res;

    pkbc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    pkbc_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_cmd),
        .rd_valid (queue_valid),
        .rd_en    (queue_pop),
        .rd_data  (queue_cmd)
    );

    pkbc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_valid),
        .cmd_pop   (queue_pop),
        .cmd       (queue_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {res.byte_count, res.packet_count, res.entry_key,
                           res.entry_valid, res.slot};

endmodule

// ----- verif/per_key_packet_byte_counter_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_key_packet_byte_counter_unit_tb - self-checking bench for the counter
// A directed list covers reset reads, filter boundaries, inserts, hits and a
// key mode change. Three random phases follow. They fill the table until it
// runs full, with hits, noise and slot reads mixed in. Every result is checked
// in order against the expected values of its directed row or against a table
// model kept inside the bench. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module per_key_packet_byte_counter_unit_tb;

    localparam int   SLOTS       = pkbc_pkg::TABLE_ENTRIES_DEFAULT;
    localparam logic KIND_COUNT  = 1'b0;
    localparam logic KIND_READ   = 1'b1;
    localparam logic MODE_SOURCE = 1'b0;
    localparam logic MODE_PORT   = 1'b1;
    localparam int   HOLD_AT     = 120;     // result count at which the sink holds off
    localparam int   HOLD_CYCLES = 300;
    localparam int   PAUSE_AT    = 80;      // item count at which the source drains
    localparam int   TAIL_CYCLES = 300;     // longer than a full-table search

    typedef struct packed {
        logic        kind;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [31:0] source_ip;
        logic [31:0] ingress_index;
        logic [6:0]  slot_index;
    } descriptor_t;

    typedef struct {
        logic              mode;
        descriptor_t       d;
        bit                known;
        pkbc_pkg::result_t want;
    } stim_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    // table model
    logic        key_mode_model;
    logic        tbl_valid   [SLOTS];
    logic [31:0] tbl_key     [SLOTS];
    logic [63:0] tbl_packets [SLOTS];
    logic [63:0] tbl_bytes   [SLOTS];

    pkbc_pkg::result_t pending[$];
    stim_row_t         directed[$];
    logic [31:0]       key_pool[16];
    int                mismatches = 0;
    int                sent_items = 0;
    bit                sender_burst = 0;

    per_key_packet_byte_counter_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // updates the table model and returns the result the item should give
    function automatic pkbc_pkg::result_t count_or_read(input descriptor_t d);
        pkbc_pkg::result_t r;
        logic [31:0]       k;
        int                free_idx;
        int                hit_idx;
        r        = '0;
        free_idx = -1;
        hit_idx  = -1;
        if (d.kind == KIND_READ) begin
            r.status = pkbc_pkg::STATUS_READ;
            r.slot   = d.slot_index;
            if (tbl_valid[d.slot_index]) begin
                r.entry_valid  = 1'b1;
                r.entry_key    = tbl_key[d.slot_index];
                r.packet_count = tbl_packets[d.slot_index];
                r.byte_count   = tbl_bytes[d.slot_index];
            end
            return r;
        end
        if (key_mode_model == MODE_SOURCE) begin
            if (d.frame_length < pkbc_pkg::ETH_HDR_BYTES ||
                d.ether_type != pkbc_pkg::IPV4_ETHERTYPE ||
                d.frame_length < pkbc_pkg::ETH_IP_HDR_BYTES) begin
                r.status = pkbc_pkg::STATUS_IGNORED;
                return r;
            end
            k = d.source_ip;
        end else begin
            k = d.ingress_index;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i]) begin
                if (hit_idx < 0 && tbl_key[i] == k) hit_idx = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (hit_idx >= 0) begin
            tbl_packets[hit_idx] = tbl_packets[hit_idx] + 64'd1;
            tbl_bytes[hit_idx]   = tbl_bytes[hit_idx] + 64'(d.frame_length);
            r.status       = pkbc_pkg::STATUS_HIT;
            r.slot         = 7'(hit_idx);
            r.entry_valid  = 1'b1;
            r.entry_key    = k;
            r.packet_count = tbl_packets[hit_idx];
            r.byte_count   = tbl_bytes[hit_idx];
        end else if (free_idx < 0) begin
            r.status    = pkbc_pkg::STATUS_FULL;
            r.entry_key = k;
        end else begin
            tbl_valid[free_idx]   = 1'b1;
            tbl_key[free_idx]     = k;
            tbl_packets[free_idx] = 64'd1;
            tbl_bytes[free_idx]   = 64'(d.frame_length);
            r.status       = pkbc_pkg::STATUS_INSERTED;
            r.slot         = 7'(free_idx);
            r.entry_valid  = 1'b1;
            r.entry_key    = k;
            r.packet_count = 64'd1;
            r.byte_count   = 64'(d.frame_length);
        end
        return r;
    endfunction

    function automatic descriptor_t random_descriptor(input logic mode, input int new_pct);
        descriptor_t d;
        int          pick;
        logic [31:0] k;
        d.kind          = KIND_COUNT;
        d.frame_length  = 16'($urandom);
        d.ether_type    = 16'($urandom);
        d.source_ip     = $urandom;
        d.ingress_index = $urandom;
        d.slot_index    = 7'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            d.kind = KIND_READ;
        end else if (pick >= 25) begin
            k = ($urandom_range(0, 99) < new_pct) ? $urandom : key_pool[$urandom_range(0, 15)];
            if (mode == MODE_SOURCE) d.source_ip = k;
            else d.ingress_index = k;
            d.ether_type   = pkbc_pkg::IPV4_ETHERTYPE;
            d.frame_length = ($urandom_range(0, 9) == 0) ? 16'hffff
                                                         : 16'($urandom_range(34, 1518));
            // broken frames: short header or foreign ethertype
            if (pick < 33) begin
                d.frame_length = 16'($urandom_range(0, 33));
            end else if (pick < 40) begin
                d.ether_type = 16'($urandom);
                if (d.ether_type == pkbc_pkg::IPV4_ETHERTYPE) d.ether_type = 16'h86dd;
            end
        end
        return d;
    endfunction

    task automatic add_row(input logic mode, input logic kind, input logic [15:0] len,
                           input logic [15:0] etype, input logic [31:0] sip,
                           input logic [31:0] port, input logic [6:0] rd_slot,
                           input bit known, input pkbc_pkg::status_t st,
                           input logic [6:0] slot,
                           input logic valid, input logic [31:0] key,
                           input logic [63:0] pk, input logic [63:0] by);
        stim_row_t row;
        row.mode   = mode;
        row.d      = '{kind, len, etype, sip, port, rd_slot};
        row.known  = known;
        row.want   = '{st, by, pk, key, valid, slot};
        directed.push_back(row);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic offer(input descriptor_t d, input bit known,
                         input pkbc_pkg::result_t want);
        int                gap;
        pkbc_pkg::result_t predicted;
        if (sent_items % 16 == 0) sender_burst = ($urandom_range(0, 3) == 0);
        gap = sender_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, d.slot_index, d.ingress_index, d.source_ip,
                          d.ether_type, d.frame_length};
        s_axis_tuser  <= d.kind;
        do @(negedge aclk); while (!s_axis_tready);
        @(posedge aclk);
        predicted = count_or_read(d);
        pending.push_back(known ? want : predicted);
        sent_items++;
        if (sent_items == PAUSE_AT) wait_idle();
    endtask

    task automatic set_mode(input logic m);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid      <= 1'b0;
        key_mode_model = m;
    endtask

    task automatic run_phase(input logic mode, input int count, input int new_pct);
        set_mode(mode);
        for (int i = 0; i < count; i++) offer(random_descriptor(mode, new_pct), 1'b0, '0);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input logic [167:0] data, input logic [2:0] st);
        pkbc_pkg::result_t want;
        if (pending.size() == 0) begin
            if (mismatches < 10) $display("%0t: result with nothing outstanding", $realtime);
            mismatches++;
            return;
        end
        want = pending.pop_front();
        compare_field("status",       64'(want.status),      64'(st));
        compare_field("slot",         64'(want.slot),        64'(data[6:0]));
        compare_field("entry_valid",  64'(want.entry_valid), 64'(data[7]));
        compare_field("entry_key",    64'(want.entry_key),   64'(data[39:8]));
        compare_field("packet_count", want.packet_count,     data[103:40]);
        compare_field("byte_count",   want.byte_count,       data[167:104]);
    endtask

    // result side
    initial begin
        int           gap;
        int           seen;
        bit           burst;
        logic [167:0] got_data;
        logic [2:0]   got_status;
        m_axis_tready = 1'b0;
        seen          = 0;
        burst         = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (seen % 16 == 0) burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 8);
            if (seen == HOLD_AT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge aclk); while (!m_axis_tvalid);
            got_data   = m_axis_tdata;
            got_status = m_axis_tuser;
            @(posedge aclk);
            check_result(got_data, got_status);
            seen++;
        end
    end

    // stimulus
    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        key_mode_model = MODE_SOURCE;
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
        key_pool[0]  = 32'h0;
        key_pool[15] = 32'hffff_ffff;

        // reads of an empty table
        add_row(MODE_SOURCE, KIND_READ, 16'h0, 16'h0, 32'h0, 32'h0, 7'd0,
                1, pkbc_pkg::STATUS_READ, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_SOURCE, KIND_READ, 16'h0, 16'h0, 32'h0, 32'h0, 7'd127,
                1, pkbc_pkg::STATUS_READ, 7'd127, 1'b0, 32'h0, 64'd0, 64'd0);
        // filter: below ethernet header, below ip header, wrong ethertype
        add_row(MODE_SOURCE, KIND_COUNT, 16'd13, pkbc_pkg::IPV4_ETHERTYPE, 32'h1, 32'h0,
                7'd0, 1, pkbc_pkg::STATUS_IGNORED, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_SOURCE, KIND_COUNT, 16'd33, pkbc_pkg::IPV4_ETHERTYPE, 32'h1, 32'h0,
                7'd0, 1, pkbc_pkg::STATUS_IGNORED, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_SOURCE, KIND_COUNT, 16'd34, 16'h0801, 32'h1, 32'h0, 7'd0,
                1, pkbc_pkg::STATUS_IGNORED, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_SOURCE, KIND_COUNT, 16'hffff, 16'hffff, 32'hffff_ffff, 32'h0, 7'd0,
                1, pkbc_pkg::STATUS_IGNORED, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_SOURCE, KIND_COUNT, 16'd0, 16'h0, 32'h0, 32'h0, 7'd0,
                1, pkbc_pkg::STATUS_IGNORED, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        // inserts and a hit at the key extremes
        add_row(MODE_SOURCE, KIND_COUNT, 16'd34, pkbc_pkg::IPV4_ETHERTYPE, 32'h0, 32'h0,
                7'd0, 1, pkbc_pkg::STATUS_INSERTED, 7'd0, 1'b1, 32'h0, 64'd1, 64'd34);
        add_row(MODE_SOURCE, KIND_COUNT, 16'hffff, pkbc_pkg::IPV4_ETHERTYPE, 32'hffff_ffff,
                32'hffff_ffff, 7'd0,
                1, pkbc_pkg::STATUS_INSERTED, 7'd1, 1'b1, 32'hffff_ffff, 64'd1, 64'd65535);
        add_row(MODE_SOURCE, KIND_COUNT, 16'd100, pkbc_pkg::IPV4_ETHERTYPE, 32'h0, 32'h1234,
                7'd0, 1, pkbc_pkg::STATUS_HIT, 7'd0, 1'b1, 32'h0, 64'd2, 64'd134);
        add_row(MODE_SOURCE, KIND_READ, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
                7'd1, 0, pkbc_pkg::STATUS_READ, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_SOURCE, KIND_READ, 16'h0, 16'h0, 32'h0, 32'h0, 7'd0,
                0, pkbc_pkg::STATUS_READ, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        // port mode: keys left by source mode are shared, every length counts
        add_row(MODE_PORT, KIND_COUNT, 16'd0, 16'h0, 32'h5, 32'h0, 7'd0,
                0, pkbc_pkg::STATUS_HIT, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_PORT, KIND_COUNT, 16'hffff, 16'hffff, 32'h0, 32'hffff_ffff, 7'd0,
                0, pkbc_pkg::STATUS_HIT, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_PORT, KIND_COUNT, 16'd13, 16'h86dd, 32'h0, 32'h5, 7'd0,
                0, pkbc_pkg::STATUS_HIT, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_PORT, KIND_COUNT, 16'hffff, 16'h0, 32'h0, 32'h5, 7'd0,
                0, pkbc_pkg::STATUS_HIT, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_PORT, KIND_READ, 16'h0, 16'h0, 32'h0, 32'h0, 7'd2,
                0, pkbc_pkg::STATUS_READ, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);
        add_row(MODE_PORT, KIND_READ, 16'h0, 16'h0, 32'h0, 32'h0, 7'd64,
                0, pkbc_pkg::STATUS_READ, 7'd0, 1'b0, 32'h0, 64'd0, 64'd0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_mode(MODE_SOURCE);
        foreach (directed[i]) begin
            if (directed[i].mode != key_mode_model) set_mode(directed[i].mode);
            offer(directed[i].d, directed[i].known, directed[i].want);
        end

        // light fill, then a port-keyed flood past capacity, then hits on a full table
        run_phase(MODE_SOURCE, 120, 10);
        run_phase(MODE_PORT, 200, 90);
        run_phase(MODE_SOURCE, 100, 30);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
